// File: hdl/fdrm_pkg.sv
// Shared types and constants for the fixed-depth radix map core.
// It depends on nothing. The top level takes its names by scoped reference.
`default_nettype none

package fdrm_pkg;

    localparam int MODE_W   = 2;
    localparam int KEY_W    = 16;
    localparam int VALUE_W  = 64;
    localparam int STATUS_W = 2;

    typedef logic [MODE_W-1:0]   mode_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [KEY_W-1:0]    key_t;
    typedef logic [VALUE_W-1:0]  value_t;

    // Request kinds.
    localparam mode_t MODE_INSERT = 2'd0;
    localparam mode_t MODE_LOOKUP = 2'd1;
    localparam mode_t MODE_REMOVE = 2'd2;
    localparam mode_t MODE_NOP    = 2'd3;

    // Result codes.
    localparam status_t STATUS_OK        = 2'd0;
    localparam status_t STATUS_NOT_FOUND = 2'd1;
    localparam status_t STATUS_POOL_FULL = 2'd2;

    // Packed stream widths, padded to whole bytes.
    localparam int IN_PACK_W  = MODE_W + KEY_W + VALUE_W;
    localparam int IN_DATA_W  = ((IN_PACK_W + 7) / 8) * 8;
    localparam int OUT_PACK_W = STATUS_W + VALUE_W;
    localparam int OUT_DATA_W = ((OUT_PACK_W + 7) / 8) * 8;

endpackage

`default_nettype wire

// File: hdl/fixed_depth_radix_map_core.sv
// Fixed-depth radix map core: a key/value map held as a radix trie in one node memory.
// Depends on fdrm_pkg for field widths, request kinds and result codes.
//
// Sequence: an item is accepted in idle, then each level of a walk over existing nodes
// spends a read state and an evaluate state, set by the single read port of the node memory
// and its registered read; a level that an insert allocates skips the read, its row being
// known empty. The result waits in the done state until the output register is free.
// One item at a time: the next item is taken only once the sequencer is back in idle.
// Reset: asynchronous, active low; clears the node counter and the root flag. The node
// memory needs no clearing pass because every node is written when it is allocated.
`default_nettype none

module fixed_depth_radix_map_core #(
    parameter int RADIX_BITS = 4,
    parameter int LEVELS     = 4,
    parameter int NODE_POOL  = 256
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    // Request stream.
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // s_tdata fields from bit 0 up: mode[1:0], key[17:2], new_value[81:18], zero pad.
    input  wire logic [fdrm_pkg::IN_DATA_W-1:0] s_tdata,

    // Result stream.
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // m_tdata fields from bit 0 up: status[1:0], found_value[65:2], zero pad.
    output logic [fdrm_pkg::OUT_DATA_W-1:0]    m_tdata
);

    // Geometry. A node row holds the child valid bits, the child links and the leaf value.
    localparam int FANOUT    = 1 << RADIX_BITS;
    localparam int NW        = $clog2(NODE_POOL);
    localparam int UW        = $clog2(NODE_POOL + 1);
    localparam int LW        = $clog2(LEVELS + 1);
    localparam int EXT_W     = LEVELS * RADIX_BITS + fdrm_pkg::KEY_W;
    localparam int DPW       = $clog2(EXT_W);
    localparam int LINK_LSB  = FANOUT;
    localparam int LEAF_LSB  = FANOUT + FANOUT * NW;
    localparam int ROW_W     = LEAF_LSB + fdrm_pkg::VALUE_W;

    // Sequencer states.
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_EVAL = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]              state_reg, state_next;
    fdrm_pkg::mode_t         mode_reg, mode_next;
    fdrm_pkg::key_t          key_reg, key_next;
    fdrm_pkg::value_t        val_reg, val_next;
    logic [NW-1:0]           node_reg, node_next;
    logic [LW-1:0]           lvl_reg, lvl_next;
    logic                    fresh_reg, fresh_next;
    logic [UW-1:0]           used_reg, used_next;
    logic                    root_reg, root_next;
    fdrm_pkg::status_t       res_status_reg, res_status_next;
    fdrm_pkg::value_t        res_value_reg, res_value_next;
    logic                    out_valid_reg, out_valid_next;
    fdrm_pkg::status_t       out_status_reg, out_status_next;
    fdrm_pkg::value_t        out_value_reg, out_value_next;

    // Node memory: one row per node, read through a registered output.
    logic [ROW_W-1:0]        node_mem [NODE_POOL];
    logic [ROW_W-1:0]        rd_row_reg;
    logic                    rd_en;
    logic                    wr_en;
    logic [ROW_W-1:0]        wr_row;

    // Walk datapath.
    logic [EXT_W-1:0]        key_ext;
    logic [LW-1:0]           lvl_m1;
    logic [DPW-1:0]          digit_pos;
    logic [RADIX_BITS-1:0]   digit;
    logic [ROW_W-1:0]        row_cur;
    logic                    cur_valid;
    logic [NW-1:0]           cur_link;
    fdrm_pkg::value_t        cur_leaf;
    logic                    pool_full;
    logic                    in_fire;
    logic                    out_free;

    assign in_fire  = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || m_tready;

    // Digits above the key's width read as zero, so the key is extended before selection.
    assign key_ext   = {{(EXT_W - fdrm_pkg::KEY_W){1'b0}}, key_reg};
    assign lvl_m1    = lvl_reg - LW'(1);
    assign digit_pos = DPW'(lvl_m1) * DPW'(RADIX_BITS);
    assign digit     = key_ext[digit_pos +: RADIX_BITS];

    // A node allocated during this item has not been written yet; its contents are known
    // to be empty, so no read is spent on it.
    assign row_cur   = fresh_reg ? '0 : rd_row_reg;
    assign cur_valid = row_cur[digit];
    assign cur_link  = row_cur[LINK_LSB + int'(digit) * NW +: NW];
    assign cur_leaf  = row_cur[LEAF_LSB +: fdrm_pkg::VALUE_W];
    assign pool_full = (used_reg == UW'(NODE_POOL));

    assign rd_en = (state_reg == S_READ);

    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        key_next        = key_reg;
        val_next        = val_reg;
        node_next       = node_reg;
        lvl_next        = lvl_reg;
        fresh_next      = fresh_reg;
        used_next       = used_reg;
        root_next       = root_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        wr_en           = 1'b0;
        wr_row          = row_cur;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    mode_next       = s_tdata[fdrm_pkg::MODE_W-1:0];
                    key_next        = s_tdata[fdrm_pkg::MODE_W +: fdrm_pkg::KEY_W];
                    val_next        = s_tdata[fdrm_pkg::MODE_W + fdrm_pkg::KEY_W +:
                                              fdrm_pkg::VALUE_W];
                    node_next       = '0;
                    lvl_next        = LW'(LEVELS);
                    fresh_next      = 1'b0;
                    res_status_next = fdrm_pkg::STATUS_OK;
                    res_value_next  = '0;
                    unique case (s_tdata[fdrm_pkg::MODE_W-1:0])
                        fdrm_pkg::MODE_INSERT:
                        begin
                            if (!root_reg)
                            begin
                                // The root is always the first node taken from the pool.
                                root_next  = 1'b1;
                                used_next  = UW'(1);
                                fresh_next = 1'b1;
                                state_next = S_EVAL;
                            end
                            else
                            begin
                                state_next = S_READ;
                            end
                        end
                        fdrm_pkg::MODE_LOOKUP,
                        fdrm_pkg::MODE_REMOVE:
                        begin
                            if (!root_reg)
                            begin
                                res_status_next = fdrm_pkg::STATUS_NOT_FOUND;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                state_next = S_READ;
                            end
                        end
                        fdrm_pkg::MODE_NOP:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_READ:
            begin
                state_next = S_EVAL;
            end

            S_EVAL:
            begin
                if (lvl_reg == '0)
                begin
                    // At the leaf: insert stores the value, lookup reports it, remove reports and clears it.
                    state_next = S_DONE;
                    if (mode_reg == fdrm_pkg::MODE_INSERT)
                    begin
                        wr_en = 1'b1;
                        wr_row[LEAF_LSB +: fdrm_pkg::VALUE_W] = val_reg;
                    end
                    else
                    begin
                        res_value_next = cur_leaf;
                        if (mode_reg == fdrm_pkg::MODE_REMOVE)
                        begin
                            wr_en = 1'b1;
                            wr_row[LEAF_LSB +: fdrm_pkg::VALUE_W] = '0;
                        end
                    end
                end
                else if (cur_valid)
                begin
                    node_next  = cur_link;
                    lvl_next   = lvl_m1;
                    fresh_next = 1'b0;
                    state_next = S_READ;
                end
                else if (mode_reg == fdrm_pkg::MODE_INSERT)
                begin
                    if (pool_full)
                    begin
                        // Nodes linked so far stay; a node taken during this item still
                        // gets its empty row written so that later walks read it cleanly.
                        wr_en           = fresh_reg;
                        res_status_next = fdrm_pkg::STATUS_POOL_FULL;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        wr_en          = 1'b1;
                        wr_row[digit]  = 1'b1;
                        wr_row[LINK_LSB + int'(digit) * NW +: NW] = used_reg[NW-1:0];
                        node_next      = used_reg[NW-1:0];
                        used_next      = used_reg + UW'(1);
                        lvl_next       = lvl_m1;
                        fresh_next     = 1'b1;
                        state_next     = S_EVAL;
                    end
                end
                else
                begin
                    res_status_next = fdrm_pkg::STATUS_NOT_FOUND;
                    state_next      = S_DONE;
                end
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_value_next  = res_value_reg;
                    state_next      = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            root_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            root_reg      <= root_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        key_reg        <= key_next;
        val_reg        <= val_next;
        node_reg       <= node_next;
        lvl_reg        <= lvl_next;
        fresh_reg      <= fresh_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        out_status_reg <= out_status_next;
        out_value_reg  <= out_value_next;
    end

    // Writes happen only in the evaluate state, and no read follows one until done and idle
    // have passed; a walk never revisits a node, so no forwarding path is needed.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            node_mem[node_reg] <= wr_row;
        end
        if (rd_en)
        begin
            rd_row_reg <= node_mem[node_reg];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(fdrm_pkg::OUT_DATA_W - fdrm_pkg::OUT_PACK_W){1'b0}},
                       out_value_reg, out_status_reg};

    // The node counter never passes the pool size.
    a_used_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= UW'(NODE_POOL))
        else $error("node counter beyond pool size");

    // No node is ever taken before the root.
    a_root_first: assert property (@(posedge clk) disable iff (!rst_n)
        !root_reg |-> used_reg == '0)
        else $error("nodes in use without a root");

    // One item at a time: an accepted item closes the request side as the sequencer leaves idle.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item accepted while one is in flight");

    // A write during a walk always goes to a node that has been allocated.
    a_write_allocated: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> UW'(node_reg) < used_reg)
        else $error("write to an unallocated node");

endmodule

`default_nettype wire
